[design/rrqs_pkg.sv]
// Shared constants, codes and control types for the round robin queue scheduler.
package rrqs_pkg;

  localparam int NUM_QUEUES    = 8;
  localparam int QUEUE_DEPTH   = 16;
  localparam int PAYLOAD_WIDTH = 32;

  // Queue and FIFO sizes are powers of two, so index wrap is plain truncation
  localparam int QW     = $clog2(NUM_QUEUES);
  localparam int DW     = $clog2(QUEUE_DEPTH);
  localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int SAW    = QW + DW;

  localparam int QID_W  = 3;
  localparam int STAT_W = 2;

  localparam logic MODE_ENQ   = 1'b0;
  localparam logic MODE_SERVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;   // capture the incoming transaction
    logic exec;   // update queues and ring, launch the store access
  } rrqs_cmd_t;

endpackage

[design/rrqs_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module rrqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/rrqs_ctrl.sv]
// Controller: accepts a transaction, sequences the execute cycle, raises the result strobe.
module rrqs_ctrl import rrqs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output rrqs_cmd_t cmd,
  output logic      out_valid
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r == S_EXEC);
  assign out_valid = valid_r;

endmodule

[design/rrqs_dp.sv]
// Datapath: per-queue FIFO pointers, active ring, payload store and result registers.
module rrqs_dp import rrqs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rrqs_cmd_t                cmd,
  input  logic                     in_mode,
  input  logic [QID_W-1:0]         in_queue_id,
  input  logic [PAYLOAD_WIDTH-1:0] in_payload,
  output logic [STAT_W-1:0]        out_status,
  output logic [QID_W-1:0]         out_served_queue,
  output logic [PAYLOAD_WIDTH-1:0] out_served_payload,
  output logic                     out_requeued
);

  // captured transaction
  logic                     mode_r;
  logic [QW-1:0]            qid_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;

  // FIFO bookkeeping
  logic [DW-1:0] fifo_head_r  [NUM_QUEUES];
  logic [DW-1:0] fifo_head_nxt[NUM_QUEUES];
  logic [DW:0]   fifo_count_r  [NUM_QUEUES];
  logic [DW:0]   fifo_count_nxt[NUM_QUEUES];

  // active ring
  logic [QW-1:0] ring_store_r [NUM_QUEUES];
  logic [QW:0]   ring_count_r, ring_count_nxt;
  logic [QW-1:0] ring_head_r, ring_head_nxt;
  logic          ring_we;
  logic [QW-1:0] ring_waddr;

  // result registers
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [QW-1:0]     sq_r, sq_nxt;
  logic              still_r, still_nxt;
  logic              pay_sel_r, pay_sel_nxt;

  logic [QW-1:0] q;
  logic [DW-1:0] hd;
  logic [DW:0]   cnt;
  logic [DW-1:0] slot;
  logic [QW-1:0] ring_tail;
  logic          enq_ok, srv_ok, srv_rd;
  logic          ram_we, ram_re;
  logic [SAW-1:0] ram_waddr, ram_raddr;
  logic [PAYLOAD_WIDTH-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      qid_r  <= in_queue_id[QW-1:0];
      pay_r  <= in_payload;
    end
  end

  assign q         = (mode_r == MODE_SERVE) ? ring_store_r[ring_head_r] : qid_r;
  assign hd        = fifo_head_r[q];
  assign cnt       = fifo_count_r[q];
  assign slot      = hd + cnt[DW-1:0];
  assign ring_tail = ring_head_r + ring_count_r[QW-1:0];

  assign enq_ok = (mode_r == MODE_ENQ) && (cnt < (DW+1)'(QUEUE_DEPTH));
  assign srv_ok = (mode_r == MODE_SERVE) && (ring_count_r != '0);
  assign srv_rd = srv_ok && (cnt != '0);

  always_comb begin
    fifo_head_nxt  = fifo_head_r;
    fifo_count_nxt = fifo_count_r;
    ring_head_nxt  = ring_head_r;
    ring_count_nxt = ring_count_r;
    ring_we        = 1'b0;
    ring_waddr     = ring_tail;
    status_nxt     = status_r;
    sq_nxt         = sq_r;
    still_nxt      = still_r;
    pay_sel_nxt    = pay_sel_r;
    if (cmd.exec) begin
      status_nxt  = ST_OK;
      sq_nxt      = '0;
      still_nxt   = 1'b0;
      pay_sel_nxt = 1'b0;
      if (mode_r == MODE_ENQ) begin
        if (!enq_ok) begin
          status_nxt = ST_FULL;
        end else begin
          fifo_count_nxt[q] = cnt + 1'b1;
          if ((cnt == '0) && (ring_count_r < (QW+1)'(NUM_QUEUES))) begin
            ring_we        = 1'b1;
            ring_count_nxt = ring_count_r + 1'b1;
          end
        end
      end else begin
        if (!srv_ok) begin
          status_nxt = ST_EMPTY;
        end else begin
          sq_nxt        = q;
          ring_head_nxt = ring_head_r + 1'b1;
          if (srv_rd) begin
            pay_sel_nxt       = 1'b1;
            fifo_head_nxt[q]  = hd + 1'b1;
            fifo_count_nxt[q] = cnt - 1'b1;
          end
          // queue goes back on the ring tail: net ring count unchanged
          if (cnt > (DW+1)'(1)) begin
            still_nxt = 1'b1;
            ring_we   = 1'b1;
          end else begin
            ring_count_nxt = ring_count_r - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fifo_head_r[i]  <= '0;
        fifo_count_r[i] <= '0;
      end
      ring_head_r  <= '0;
      ring_count_r <= '0;
    end else begin
      fifo_head_r  <= fifo_head_nxt;
      fifo_count_r <= fifo_count_nxt;
      ring_head_r  <= ring_head_nxt;
      ring_count_r <= ring_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_store_r[ring_waddr] <= q;
    end
    status_r  <= status_nxt;
    sq_r      <= sq_nxt;
    still_r   <= still_nxt;
    pay_sel_r <= pay_sel_nxt;
  end

  assign ram_we    = cmd.exec && enq_ok;
  assign ram_re    = cmd.exec && srv_rd;
  assign ram_waddr = {q, slot};
  assign ram_raddr = {q, hd};

  rrqs_ram #(
    .WIDTH(PAYLOAD_WIDTH),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(pay_r),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_status         = status_r;
  assign out_served_queue   = QID_W'(sq_r);
  assign out_served_payload = pay_sel_r ? ram_rdata : '0;
  assign out_requeued       = still_r;

endmodule

[design/round_robin_queue_scheduler_top.sv]
// Top level of the round robin queue scheduler: controller plus datapath.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  -------------------------
//   input    in_mode, in_queue_id, in_payload        start & !busy
//   result   out_status, out_served_queue,           out_valid, one cycle
//            out_served_payload, out_requeued
//
// Every transaction is accepted, then runs the execute state, in which pointers,
// ring and payload store are updated or read; the result strobe comes in the
// cycle after execute, together with the registered store read, and a new
// transaction may be accepted in that same cycle.
// Reset (rst_n low, synchronous) empties all queues and the ring; the payload
// store needs no clearing. Results cannot be stalled by the receiver.
module round_robin_queue_scheduler_top import rrqs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_mode,
  input  logic [QID_W-1:0]         in_queue_id,
  input  logic [PAYLOAD_WIDTH-1:0] in_payload,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [QID_W-1:0]         out_served_queue,
  output logic [PAYLOAD_WIDTH-1:0] out_served_payload,
  output logic                     out_requeued
);

  rrqs_cmd_t cmd;

  rrqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .out_valid(out_valid)
  );

  rrqs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_mode           (in_mode),
    .in_queue_id       (in_queue_id),
    .in_payload        (in_payload),
    .out_status        (out_status),
    .out_served_queue  (out_served_queue),
    .out_served_payload(out_served_payload),
    .out_requeued      (out_requeued)
  );

endmodule
